[rtl/heater_pid_time_proportional_assert.svh]
// Assertion macros for the heater PID controller, switched off by NO_ASSERTIONS.
`ifndef HEATER_PID_TIME_PROPORTIONAL_ASSERT_SVH
`define HEATER_PID_TIME_PROPORTIONAL_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset
`define HPTP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("heater pid controller assertion failed");

// Check a property on every clock edge, reset included
`define HPTP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("heater pid controller assertion failed");

`else

`define HPTP_ASSERT(lbl, clk, rst, prop)
`define HPTP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[rtl/hptp_pkg.sv]
// Constants and fixed-point helper functions for the heater PID controller.
`timescale 1ns / 1ps

package hptp_pkg;

   localparam int unsigned SAMPLE_W  = 10;
   localparam int unsigned TEMP_W    = 9;
   localparam int unsigned TARGET_W  = 10;
   localparam int unsigned WORD_W    = 16;
   localparam int unsigned SUM_W     = 17;
   localparam int unsigned PHASE_W   = 6;
   localparam int unsigned DISPLAY_W = 10;

   localparam logic [TARGET_W-1:0]  TARGET_RESET = 10'd420;  // 300 degrees * 14 / 10
   localparam logic [SAMPLE_W-1:0]  FAULT_LEVEL  = 10'd1000;
   localparam logic [DISPLAY_W-1:0] DISPLAY_MAX  = 10'd1023;

   // Reciprocals: /5 as *3277>>14, /10 as *52429>>19, /7 as *18725>>17
   localparam logic [15:0] RECIP_5  = 16'd3277;
   localparam logic [15:0] RECIP_10 = 16'd52429;
   localparam logic [15:0] RECIP_7  = 16'd18725;

   // Convert degrees to sensor units: floor(t * 14 / 10) = floor(t * 7 / 5)
   function automatic logic [TARGET_W-1:0] target_to_adc(input logic [TEMP_W-1:0] t);
      logic [11:0] scaled;
      logic [25:0] prod;
      scaled = {3'b000, t} * 12'd7;
      prod   = 26'(scaled) * 26'(RECIP_5);
      return prod[23:14];
   endfunction

   // Signed divide by ten, truncated toward zero
   function automatic logic [WORD_W-1:0] div10_signed(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] mag;
      logic [31:0]       prod;
      logic [12:0]       quo;
      mag  = v[WORD_W-1] ? (16'd0 - v) : v;
      prod = 32'(mag) * 32'(RECIP_10);
      quo  = prod[31:19];
      return v[WORD_W-1] ? (16'd0 - {3'b000, quo}) : {3'b000, quo};
   endfunction

   // Window average: floor(s / 56) as floor(floor(s / 8) / 7), saturated to 10 bits
   function automatic logic [DISPLAY_W-1:0] average56(input logic [SUM_W-1:0] s);
      logic [13:0] eighth;
      logic [28:0] prod;
      logic [11:0] quo;
      eighth = s[16:3];
      prod   = 29'(eighth) * 29'(RECIP_7);
      quo    = prod[28:17];
      return (quo > 12'(DISPLAY_MAX)) ? DISPLAY_MAX : quo[9:0];
   endfunction

endpackage

[rtl/heater_pid_time_proportional.sv]
// Top level of the heater PID controller with time-proportional heater output.
`timescale 1ns / 1ps

// Heater PID controller. Each request beat carries one 10-bit sensor sample
// and produces exactly one response beat with the heater on/off decision, the
// 16-bit wrapping PID drive, the averaged display temperature and a flag that
// marks the sample closing a PWM_STEPS-sample window. Samples enter an input
// register, the PID update runs combinationally against the stored integral,
// previous error, phase and window sum, and the result lands in an output
// register. One beat is accepted every cycle while the response side keeps
// up. The loop that sets this rate is the state update, whose deepest path is
// the divide-by-ten of the integral (one 16x16 multiply) feeding the drive add
// and the phase compare. The user must write the set temperature through the
// csr port only while no beat is in flight; the block does not enforce this.
// The set temperature is converted to sensor units at write time.

`include "heater_pid_time_proportional_assert.svh"

module heater_pid_time_proportional #(
   parameter int PWM_STEPS = 40
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_en,
   input  logic [8:0]  csr_write_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [9:0]  req_adc_sample,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_heater_on,
   output logic [15:0] rsp_drive_value,
   output logic [9:0]  rsp_shown_temp,
   output logic        rsp_shown_updated
);

   // control registers
   logic in_valid_ff,  in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   // PID and window state
   logic [hptp_pkg::TARGET_W-1:0]  target_ff,   target_in;
   logic [hptp_pkg::PHASE_W-1:0]   phase_ff,    phase_in;
   logic [hptp_pkg::SUM_W-1:0]     sum_ff,      sum_in;
   logic [hptp_pkg::WORD_W-1:0]    integral_ff, integral_in;
   logic [hptp_pkg::WORD_W-1:0]    last_err_ff, last_err_in;
   logic [hptp_pkg::DISPLAY_W-1:0] display_ff,  display_in;

   // payload registers
   logic [hptp_pkg::SAMPLE_W-1:0]  sample_ff;
   logic                           heater_on_ff,  heater_on_in;
   logic [hptp_pkg::WORD_W-1:0]    drive_ff,      drive_in;
   logic                           updated_ff,    updated_in;

   logic req_fire;
   logic advance;

   logic [hptp_pkg::PHASE_W-1:0] phase_next;
   logic [hptp_pkg::SUM_W-1:0]   sum_next;
   logic                         window_close;
   logic [hptp_pkg::WORD_W-1:0]  err;
   logic [hptp_pkg::WORD_W-1:0]  deriv;
   logic [hptp_pkg::WORD_W-1:0]  integ_part;
   logic [hptp_pkg::WORD_W-1:0]  drive;

   // Handshake: the item in the input register moves whenever the output slot frees
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Advance the phase and the window sum, close the window at PWM_STEPS
   always_comb begin
      phase_next   = phase_ff + 6'd1;
      sum_next     = sum_ff + 17'(sample_ff);
      window_close = (phase_next >= 6'(PWM_STEPS));
   end

   // PID terms, all wrapping at 16 bits
   always_comb begin
      err        = 16'(target_ff) - 16'(sample_ff);
      deriv      = err - last_err_ff;
      integ_part = hptp_pkg::div10_signed(integral_ff);
      drive      = err + integ_part + {deriv[14:0], 1'b0};
   end

   // Next state of the PID loop and the result fields
   always_comb begin
      target_in    = target_ff;
      phase_in     = phase_ff;
      sum_in       = sum_ff;
      integral_in  = integral_ff;
      last_err_in  = last_err_ff;
      display_in   = display_ff;
      heater_on_in = heater_on_ff;
      drive_in     = drive_ff;
      updated_in   = updated_ff;

      if (csr_write_en) begin
         target_in = hptp_pkg::target_to_adc(csr_write_data);
      end

      if (advance) begin
         phase_in    = window_close ? '0 : phase_next;
         sum_in      = window_close ? '0 : sum_next;
         display_in  = window_close ? hptp_pkg::average56(sum_next) : display_ff;
         integral_in = integral_ff + err;
         last_err_in = err;
         drive_in    = drive;
         updated_in  = window_close;
         heater_on_in = !(($signed(drive) < $signed({10'b0, phase_in}))
                          || (sample_ff > hptp_pkg::FAULT_LEVEL));
      end
   end

   // Hold control and PID state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= hptp_pkg::TARGET_RESET;
         phase_ff     <= '0;
         sum_ff       <= '0;
         integral_ff  <= '0;
         last_err_ff  <= '0;
         display_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         target_ff    <= target_in;
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         integral_ff  <= integral_in;
         last_err_ff  <= last_err_in;
         display_ff   <= display_in;
      end
   end

   // Capture the request beat and the result fields
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_adc_sample;
      end
      heater_on_ff <= heater_on_in;
      drive_ff     <= drive_in;
      updated_ff   <= updated_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_heater_on     = heater_on_ff;
   assign rsp_drive_value   = drive_ff;
   assign rsp_shown_temp    = display_ff;
   assign rsp_shown_updated = updated_ff;

   // Phase never reaches the window length
   `HPTP_ASSERT(a_phase_range, clock, reset, phase_ff < 6'(PWM_STEPS))
   // A beat that closed a window leaves phase and sum cleared
   `HPTP_ASSERT(a_window_cleared, clock, reset, rsp_valid_ff && updated_ff |-> phase_ff == '0 && sum_ff == '0)
   // The stall toward the request side only comes from a held item
   `HPTP_ASSERT(a_stall_held, clock, reset, req_stall |-> in_valid_ff && rsp_valid_ff)
   // An item facing an empty output slot is always delivered next cycle
   `HPTP_ASSERT(a_item_moves, clock, reset, in_valid_ff && !rsp_valid_ff |=> rsp_valid_ff)
   // The previous error follows the error of each delivered item
   `HPTP_ASSERT(a_last_err, clock, reset, advance |=> last_err_ff == $past(err))

endmodule

[verif/tb.sv]
// Self-checking testbench for the heater PID controller with time-proportional output.
`timescale 1ns / 1ps

module tb;

   localparam int PWM_STEPS      = 40;
   localparam int TEMP_NUM       = 14;
   localparam int TEMP_DEN       = 10;
   localparam int INT_DIV        = 10;
   localparam int AVG_DIV        = 56;
   localparam int SENSOR_FAULT   = 1000;
   localparam int DISPLAY_TOP    = 1023;
   localparam int RESET_TARGET   = 300;
   localparam int RESET_CYCLES   = 6;
   localparam int SETTLE_CYCLES  = 8;
   localparam int CYCLE_LIMIT    = 250000;
   localparam int SEG_ITEMS      = 90;
   localparam int NUM_SEGMENTS   = 6;
   localparam int NUM_DIRECTED   = 21;

   typedef enum logic { ROW_SAMPLE, ROW_TARGET } row_kind_type;
   typedef enum int { LEAN_NONE, LEAN_LOW, LEAN_HIGH } sample_lean_type;
   typedef enum int { IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY, IDLE_OFF } idle_mode_type;

   typedef struct packed {
      logic        heater_on;
      logic [15:0] drive;
      logic [9:0]  shown;
      logic        updated;
   } heater_result_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [9:0]        value;
      logic              typed;
      heater_result_type typed_res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                            csr_write_en;
   logic [hptp_pkg::TEMP_W-1:0]     csr_write_data;
   logic                            req_valid;
   logic                            req_stall;
   logic [hptp_pkg::SAMPLE_W-1:0]   req_adc_sample;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic                            rsp_heater_on;
   logic [hptp_pkg::WORD_W-1:0]     rsp_drive_value;
   logic [hptp_pkg::DISPLAY_W-1:0]  rsp_shown_temp;
   logic                            rsp_shown_updated;

   // controller state as the testbench sees it
   logic [8:0]  pid_target_temp;
   logic [5:0]  pid_phase;
   logic [16:0] pid_sum;
   logic [15:0] pid_integral;
   logic [15:0] pid_last_error;
   logic [9:0]  pid_display;

   heater_result_type expected_results[$];
   int                mismatches  = 0;
   int                cycle_count = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;

   stim_row_type directed_rows [NUM_DIRECTED];

   heater_pid_time_proportional #(
      .PWM_STEPS(PWM_STEPS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_adc_sample   (req_adc_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_heater_on    (rsp_heater_on),
      .rsp_drive_value  (rsp_drive_value),
      .rsp_shown_temp   (rsp_shown_temp),
      .rsp_shown_updated(rsp_shown_updated)
   );

   always #2 clock = ~clock;

   // Advance the PID state by one sample and return the response it causes
   function automatic heater_result_type pid_advance(input logic [9:0] sample);
      heater_result_type  res;
      logic [16:0]        avg;
      logic [15:0]        target_adc;
      logic [15:0]        err;
      logic [15:0]        deriv;
      logic [15:0]        drive;
      logic signed [15:0] integ_part;
      res.updated = 1'b0;
      pid_phase   = pid_phase + 6'd1;
      pid_sum     = pid_sum + 17'(sample);
      if (int'(pid_phase) >= PWM_STEPS) begin
         avg         = pid_sum / 17'(AVG_DIV);
         pid_phase   = 6'd0;
         pid_display = (int'(avg) > DISPLAY_TOP) ? 10'(DISPLAY_TOP) : avg[9:0];
         pid_sum     = 17'd0;
         res.updated = 1'b1;
      end
      target_adc = 16'((int'(pid_target_temp) * TEMP_NUM) / TEMP_DEN);
      err        = target_adc - 16'(sample);
      deriv      = err - pid_last_error;
      integ_part = $signed(pid_integral) / $signed(16'(INT_DIV));
      drive      = err + 16'(integ_part) + (deriv << 1);
      pid_integral   = pid_integral + err;
      pid_last_error = err;
      res.heater_on = !((int'($signed(drive)) < int'(pid_phase)) ||
                        (int'(sample) > SENSOR_FAULT));
      res.drive     = drive;
      res.shown     = pid_display;
      return res;
   endfunction

   // Pick a sample: a low or high band per lean, extremes, the fault boundary, near the target, or anywhere
   function automatic logic [9:0] pick_sample(input sample_lean_type lean);
      int r;
      int center;
      int v;
      r      = $urandom_range(0, 99);
      center = (int'(pid_target_temp) * TEMP_NUM) / TEMP_DEN;
      if (lean == LEAN_LOW && r < 50) return 10'($urandom_range(0, 63));
      if (lean == LEAN_HIGH && r < 50) return 10'($urandom_range(960, 1023));
      if (r < 58) return 10'd0;
      if (r < 66) return 10'd1023;
      if (r < 72) return 10'($urandom_range(SENSOR_FAULT - 1, SENSOR_FAULT + 2));
      if (r < 85) begin
         v = center + $urandom_range(0, 32) - 16;
         if (v < 0) v = 0;
         if (v > 1023) v = 1023;
         return 10'(v);
      end
      return 10'($urandom_range(0, 1023));
   endfunction

   function automatic int idle_gap(input int pct);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(0, 99) < pct) gap++;
      return gap;
   endfunction

   // Offer one sample beat, hold it through stalls, record its response
   task automatic push_sample(input logic [9:0] sample, input logic typed,
                              input heater_result_type typed_res);
      heater_result_type res;
      int                gap;
      gap = idle_gap(send_idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_adc_sample <= sample;
      do @(posedge clock); while (req_stall);
      res = pid_advance(sample);
      expected_results.push_back(typed ? typed_res : res);
   endtask

   // Drain every response, let the pipeline settle, then write the set temperature
   task automatic write_target(input logic [8:0] temp);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= temp;
      @(posedge clock);
      csr_write_en    <= 1'b0;
      pid_target_temp = temp;
   endtask

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_SENDER_LIGHT: begin
            send_idle_pct = 28;
            recv_idle_pct = 78;
         end
         IDLE_SENDER_HEAVY: begin
            send_idle_pct = 78;
            recv_idle_pct = 28;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   // Stall the response side at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Check each accepted response beat against the oldest expectation
   always @(posedge clock) begin
      heater_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("response beat with nothing expected");
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_heater_on !== want.heater_on) begin
               $error("heater_on: expected %0d, got %0d", want.heater_on, rsp_heater_on);
               mismatches++;
            end
            if (rsp_drive_value !== want.drive) begin
               $error("drive_value: expected %0d, got %0d",
                      $signed(want.drive), $signed(rsp_drive_value));
               mismatches++;
            end
            if (rsp_shown_temp !== want.shown) begin
               $error("shown_temp: expected %0d, got %0d", want.shown, rsp_shown_temp);
               mismatches++;
            end
            if (rsp_shown_updated !== want.updated) begin
               $error("shown_updated: expected %0d, got %0d",
                      want.updated, rsp_shown_updated);
               mismatches++;
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      logic [8:0]        seg_target [NUM_SEGMENTS];
      sample_lean_type   seg_lean   [NUM_SEGMENTS];
      idle_mode_type     seg_idle   [NUM_SEGMENTS];
      heater_result_type none;

      none = '0;
      // first sample after reset: error 420, drive 3*420; then full-scale fault sample
      directed_rows = '{
         '{ROW_SAMPLE, 10'd0,    1'b1, '{1'b1, 16'd1260,  10'd0, 1'b0}},
         '{ROW_SAMPLE, 10'd1023, 1'b1, '{1'b0, 16'hF5D1,  10'd0, 1'b0}},
         '{ROW_SAMPLE, 10'd1000, 1'b0, '0},
         '{ROW_SAMPLE, 10'd1001, 1'b0, '0},
         '{ROW_SAMPLE, 10'd420,  1'b0, '0},
         '{ROW_SAMPLE, 10'd421,  1'b0, '0},
         '{ROW_TARGET, 10'd0,    1'b0, '0},
         '{ROW_SAMPLE, 10'd0,    1'b0, '0},
         '{ROW_SAMPLE, 10'd1023, 1'b0, '0},
         '{ROW_SAMPLE, 10'd1,    1'b0, '0},
         '{ROW_TARGET, 10'd511,  1'b0, '0},
         '{ROW_SAMPLE, 10'd0,    1'b0, '0},
         '{ROW_SAMPLE, 10'd0,    1'b0, '0},
         '{ROW_SAMPLE, 10'd1023, 1'b0, '0},
         '{ROW_SAMPLE, 10'd715,  1'b0, '0},
         '{ROW_TARGET, 10'd500,  1'b0, '0},
         '{ROW_SAMPLE, 10'd700,  1'b0, '0},
         '{ROW_SAMPLE, 10'd512,  1'b0, '0},
         '{ROW_SAMPLE, 10'd341,  1'b0, '0},
         '{ROW_SAMPLE, 10'd682,  1'b0, '0},
         '{ROW_SAMPLE, 10'd999,  1'b0, '0}
      };

      seg_target = '{9'd0, 9'd511, 9'd500, 9'($urandom_range(0, 511)),
                     9'd300, 9'($urandom_range(0, 511))};
      seg_lean   = '{LEAN_HIGH, LEAN_LOW, LEAN_NONE, LEAN_NONE, LEAN_LOW, LEAN_NONE};
      seg_idle   = '{IDLE_SENDER_LIGHT, IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY,
                     IDLE_SENDER_HEAVY, IDLE_OFF, IDLE_OFF};

      // drive every input to a known level and hold reset
      reset          <= 1'b1;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      req_valid      <= 1'b0;
      req_adc_sample <= '0;
      pid_target_temp = 9'(RESET_TARGET);
      pid_phase       = '0;
      pid_sum         = '0;
      pid_integral    = '0;
      pid_last_error  = '0;
      pid_display     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      set_idle(IDLE_SENDER_LIGHT);
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_TARGET)
            write_target(directed_rows[i].value[8:0]);
         else
            push_sample(directed_rows[i].value, directed_rows[i].typed,
                        directed_rows[i].typed_res);
      end

      // random segments, each under its own set temperature and idle pattern
      for (int s = 0; s < NUM_SEGMENTS; s++) begin
         write_target(seg_target[s]);
         set_idle(seg_idle[s]);
         for (int n = 0; n < SEG_ITEMS; n++)
            push_sample(pick_sample(seg_lean[s]), 1'b0, none);
      end

      // drain and settle
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("responses still expected: %0d", expected_results.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
